@@ hdl/grr_pkg.sv @@
`default_nettype none

package grr_pkg;

    // Sizes fixed by the item fields
    localparam int FONT_BYTES   = 4096;
    localparam int ADDR_W       = 12;
    localparam int COORD_W      = 9;
    localparam int COLOR_W      = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = 1;

    // Opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_PEN  = 2'd1;
    localparam logic [1:0] OP_DRAW = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_SET   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_MODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOLD       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_TEXT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FG_INDEX   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG_INDEX   = 3'd5;

    // Character sets
    localparam logic [1:0] CS_FIXED_DOWN32   = 2'd0;
    localparam logic [1:0] CS_FIXED_UP64     = 2'd1;
    localparam logic [1:0] CS_LOADABLE_DOWN32 = 2'd2;
    localparam logic [1:0] CS_LOADABLE_UP32  = 2'd3;

    // Write modes
    localparam logic [1:0] WM_WRITE   = 2'd0;
    localparam logic [1:0] WM_ERASE   = 2'd1;
    localparam logic [1:0] WM_REWRITE = 2'd2;
    localparam logic [1:0] WM_INVERSE = 2'd3;

    // Code offsets, 8-bit wrap
    localparam logic [7:0] CODE_DOWN32 = 8'hE0;
    localparam logic [7:0] CODE_UP64   = 8'd64;
    localparam logic [7:0] CODE_UP32   = 8'd32;

    localparam logic [COORD_W-1:0] COORD_MASK = 9'h1FF;
    localparam logic [COORD_W-1:0] Y_OFF      = 9'd15;
    localparam logic [COORD_W-1:0] Y_OFF_BOLD = 9'd30;
    localparam logic [COORD_W-1:0] X_STEP     = 9'd8;
    localparam logic [COORD_W-1:0] X_STEP_BOLD = 9'd16;

    localparam logic [COLOR_W-1:0] FG_RESET = 3'd1;
    localparam logic [COLOR_W-1:0] BG_RESET = 3'd0;

    // One word from the front to the back
    typedef struct packed {
        logic                is_draw;
        logic                loadable;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          data;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                step2;
        logic                dbl;
        logic                paint;
        logic [COLOR_W-1:0]  main_color;
        logic [COLOR_W-1:0]  alt_color;
    } cmd_t;

    // Row attributes carried with a font read
    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                dbl;
        logic                paint;
        logic [COLOR_W-1:0]  main_color;
        logic [COLOR_W-1:0]  alt_color;
        logic                last;
    } span_t;

endpackage

`default_nettype wire

@@ hdl/glyph_row_rasterizer.sv @@
// Load and pen words are taken one per cycle while the command queue has room.
// A draw word yields GLYPH_ROWS spans through the queue and the command, font read and
// output registers, then one span per cycle while span_stall is low; the back end takes
// no new word until its last row issues (one glyph row a cycle from a single read port).
// Reset clears the pen to zero, the registers to their defaults and the queue;
// the font memories are not cleared and hold nothing until loaded.
`default_nettype none

module glyph_row_rasterizer #(
    parameter int GLYPH_ROWS          = 16,
    parameter int LOADABLE_FONT_BYTES = 2048
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic [1:0]                          opcode,
    input  wire logic [7:0]                          char_code,
    input  wire logic                                font_bank,
    input  wire logic [grr_pkg::ADDR_W-1:0]          font_address,
    input  wire logic [7:0]                          font_data,
    input  wire logic [grr_pkg::COORD_W-1:0]         pen_x,
    input  wire logic [grr_pkg::COORD_W-1:0]         pen_y,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [grr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [grr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                     span_valid,
    input  wire logic                                span_stall,
    output logic [grr_pkg::COORD_W-1:0]              span_x,
    output logic [grr_pkg::COORD_W-1:0]              span_y,
    output logic [7:0]                               set_mask,
    output logic                                     double_size,
    output logic                                     paint_unset,
    output logic [grr_pkg::COLOR_W-1:0]              main_color,
    output logic [grr_pkg::COLOR_W-1:0]              alt_color,
    output logic                                     last_row
);

    logic           q_full;
    logic           q_push;
    grr_pkg::cmd_t  q_cmd;
    logic           q_valid;
    logic           q_pop;
    grr_pkg::cmd_t  q_head;

    grr_front #(
        .LOADABLE_FONT_BYTES(LOADABLE_FONT_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .char_code    (char_code),
        .font_bank    (font_bank),
        .font_address (font_address),
        .font_data    (font_data),
        .pen_x        (pen_x),
        .pen_y        (pen_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    grr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    grr_back #(
        .GLYPH_ROWS          (GLYPH_ROWS),
        .LOADABLE_FONT_BYTES (LOADABLE_FONT_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (q_head),
        .cmd_pop     (q_pop),
        .span_valid  (span_valid),
        .span_stall  (span_stall),
        .span_x      (span_x),
        .span_y      (span_y),
        .set_mask    (set_mask),
        .double_size (double_size),
        .paint_unset (paint_unset),
        .main_color  (main_color),
        .alt_color   (alt_color),
        .last_row    (last_row)
    );

endmodule

`default_nettype wire

@@ hdl/grr_front.sv @@
`default_nettype none

module grr_front #(
    parameter int LOADABLE_FONT_BYTES = 2048
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic [1:0]                          opcode,
    input  wire logic [7:0]                          char_code,
    input  wire logic                                font_bank,
    input  wire logic [grr_pkg::ADDR_W-1:0]          font_address,
    input  wire logic [7:0]                          font_data,
    input  wire logic [grr_pkg::COORD_W-1:0]         pen_x,
    input  wire logic [grr_pkg::COORD_W-1:0]         pen_y,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [grr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [grr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output grr_pkg::cmd_t                            q_cmd
);

    localparam int WRAP_STEPS = grr_pkg::FONT_BYTES / LOADABLE_FONT_BYTES;
    localparam logic [grr_pkg::ADDR_W:0] LFB_W = (grr_pkg::ADDR_W + 1)'(LOADABLE_FONT_BYTES);

    logic [1:0]                       char_set_reg;
    logic [1:0]                       write_mode_reg;
    logic                             bold_reg;
    logic                             fast_text_reg;
    logic [grr_pkg::COLOR_W-1:0]      fg_reg;
    logic [grr_pkg::COLOR_W-1:0]      bg_reg;
    logic [grr_pkg::COORD_W-1:0]      pen_x_reg;
    logic [grr_pkg::COORD_W-1:0]      pen_y_reg;
    logic [grr_pkg::COORD_W-1:0]      pen_x_next;

    logic                             accept;
    logic [7:0]                       glyph;
    logic                             draw_loadable;
    logic                             loadable;
    logic [grr_pkg::ADDR_W-1:0]       raw_addr;
    logic [grr_pkg::ADDR_W:0]         wrap_addr;
    logic [grr_pkg::COORD_W-1:0]      y_sum;

    assign cfg_ready  = 1'b1;
    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign q_push     = accept && (opcode == grr_pkg::OP_LOAD || opcode == grr_pkg::OP_DRAW);

    always_comb
    begin
        case (char_set_reg)
            grr_pkg::CS_FIXED_DOWN32:    glyph = char_code + grr_pkg::CODE_DOWN32;
            grr_pkg::CS_FIXED_UP64:      glyph = char_code + grr_pkg::CODE_UP64;
            grr_pkg::CS_LOADABLE_DOWN32: glyph = char_code + grr_pkg::CODE_DOWN32;
            default:                     glyph = char_code + grr_pkg::CODE_UP32;
        endcase
    end

    assign draw_loadable = char_set_reg[1];
    assign loadable = (opcode == grr_pkg::OP_DRAW) ? draw_loadable : font_bank;
    assign raw_addr = (opcode == grr_pkg::OP_DRAW) ? {glyph, 4'b0000} : font_address;

    // Reduce into the loadable store with repeated compare and subtract
    always_comb
    begin
        wrap_addr = {1'b0, raw_addr};
        if (loadable)
        begin
            for (int k = 0; k < WRAP_STEPS; k++)
            begin
                if (wrap_addr >= LFB_W)
                    wrap_addr = wrap_addr - LFB_W;
            end
        end
    end

    assign y_sum = pen_y_reg + (bold_reg ? grr_pkg::Y_OFF_BOLD : grr_pkg::Y_OFF);

    always_comb
    begin
        q_cmd            = '0;
        q_cmd.is_draw    = (opcode == grr_pkg::OP_DRAW);
        q_cmd.loadable   = loadable;
        q_cmd.addr       = wrap_addr[grr_pkg::ADDR_W-1:0];
        q_cmd.data       = font_data;
        q_cmd.x          = pen_x_reg;
        q_cmd.y          = y_sum ^ grr_pkg::COORD_MASK;
        q_cmd.main_color = (write_mode_reg inside {grr_pkg::WM_ERASE, grr_pkg::WM_INVERSE})
                           ? bg_reg : fg_reg;
        if (!fast_text_reg)
        begin
            q_cmd.step2 = bold_reg;
            q_cmd.dbl   = bold_reg;
            q_cmd.paint = (write_mode_reg inside {grr_pkg::WM_REWRITE, grr_pkg::WM_INVERSE});
            if (write_mode_reg == grr_pkg::WM_REWRITE)
                q_cmd.alt_color = bg_reg;
            else if (write_mode_reg == grr_pkg::WM_INVERSE)
                q_cmd.alt_color = fg_reg;
        end
    end

    assign pen_x_next = pen_x_reg + (bold_reg ? grr_pkg::X_STEP_BOLD : grr_pkg::X_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_set_reg   <= grr_pkg::CS_FIXED_DOWN32;
            write_mode_reg <= grr_pkg::WM_WRITE;
            bold_reg       <= 1'b0;
            fast_text_reg  <= 1'b0;
            fg_reg         <= grr_pkg::FG_RESET;
            bg_reg         <= grr_pkg::BG_RESET;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    grr_pkg::CFG_CHAR_SET:   char_set_reg   <= cfg_data[1:0];
                    grr_pkg::CFG_WRITE_MODE: write_mode_reg <= cfg_data[1:0];
                    grr_pkg::CFG_BOLD:       bold_reg       <= cfg_data[0];
                    grr_pkg::CFG_FAST_TEXT:  fast_text_reg  <= cfg_data[0];
                    grr_pkg::CFG_FG_INDEX:   fg_reg         <= cfg_data[grr_pkg::COLOR_W-1:0];
                    grr_pkg::CFG_BG_INDEX:   bg_reg         <= cfg_data[grr_pkg::COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (accept && opcode == grr_pkg::OP_PEN)
            begin
                pen_x_reg <= pen_x;
                pen_y_reg <= pen_y;
            end
            else if (accept && opcode == grr_pkg::OP_DRAW && !fast_text_reg)
            begin
                pen_x_reg <= pen_x_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/grr_queue.sv @@
`default_nettype none

module grr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire grr_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output grr_pkg::cmd_t       head
);

    grr_pkg::cmd_t                   entry_reg [grr_pkg::QUEUE_DEPTH];
    logic [grr_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [grr_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [grr_pkg::QUEUE_PTR_W:0]   count_reg;

    assign full  = (count_reg == (grr_pkg::QUEUE_PTR_W + 1)'(grr_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

@@ hdl/grr_back.sv @@
`default_nettype none

module grr_back #(
    parameter int GLYPH_ROWS          = 16,
    parameter int LOADABLE_FONT_BYTES = 2048
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire grr_pkg::cmd_t                 cmd,
    output logic                               cmd_pop,
    output logic                               span_valid,
    input  wire logic                          span_stall,
    output logic [grr_pkg::COORD_W-1:0]        span_x,
    output logic [grr_pkg::COORD_W-1:0]        span_y,
    output logic [7:0]                         set_mask,
    output logic                               double_size,
    output logic                               paint_unset,
    output logic [grr_pkg::COLOR_W-1:0]        main_color,
    output logic [grr_pkg::COLOR_W-1:0]        alt_color,
    output logic                               last_row
);

    localparam int RW   = $clog2(GLYPH_ROWS);
    localparam int LA_W = $clog2(LOADABLE_FONT_BYTES);
    localparam logic [grr_pkg::ADDR_W:0] LFB_W = (grr_pkg::ADDR_W + 1)'(LOADABLE_FONT_BYTES);
    localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_ROWS - 1);

    typedef enum logic {ST_IDLE, ST_DRAW} state_t;

    state_t                         state_reg;
    grr_pkg::cmd_t                  cur_reg;
    logic [grr_pkg::ADDR_W-1:0]     addr_reg;
    logic [grr_pkg::ADDR_W-1:0]     addr_next;
    logic [grr_pkg::ADDR_W:0]       addr_sum;
    logic [RW-1:0]                  row_reg;
    logic [grr_pkg::COORD_W-1:0]    y_reg;
    logic [grr_pkg::COORD_W-1:0]    y_next;

    logic                           s1_valid_reg;
    logic                           s1_loadable_reg;
    grr_pkg::span_t                 s1_reg;
    logic                           span_valid_reg;
    grr_pkg::span_t                 span_reg;
    logic [7:0]                     mask_reg;

    logic [7:0]                     fixed_mem [grr_pkg::FONT_BYTES];
    logic [7:0]                     loadable_mem [LOADABLE_FONT_BYTES];
    logic [7:0]                     fixed_rd_reg;
    logic [7:0]                     loadable_rd_reg;

    logic                           s1_adv;
    logic                           issue;
    logic                           is_last;
    grr_pkg::span_t                 row_attr;

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    assign s1_adv  = s1_valid_reg && (!span_valid_reg || !span_stall);
    assign issue   = (state_reg == ST_DRAW) && (!s1_valid_reg || s1_adv);
    assign is_last = (row_reg == LAST_ROW);

    // Step to the next glyph row, wrapping inside the loadable store
    always_comb
    begin
        addr_sum = {1'b0, addr_reg} + 1'b1;
        if (cur_reg.loadable && addr_sum >= LFB_W)
            addr_sum = addr_sum - LFB_W;
        addr_next = addr_sum[grr_pkg::ADDR_W-1:0];
    end

    assign y_next = y_reg + {{(grr_pkg::COORD_W-2){1'b0}}, cur_reg.step2, !cur_reg.step2};

    always_comb
    begin
        row_attr.x          = cur_reg.x;
        row_attr.y          = y_reg;
        row_attr.dbl        = cur_reg.dbl;
        row_attr.paint      = cur_reg.paint;
        row_attr.main_color = cur_reg.main_color;
        row_attr.alt_color  = cur_reg.alt_color;
        row_attr.last       = is_last;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && !cmd.is_draw && !cmd.loadable)
            fixed_mem[cmd.addr] <= cmd.data;
        if (issue && !cur_reg.loadable)
            fixed_rd_reg <= fixed_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && !cmd.is_draw && cmd.loadable)
            loadable_mem[cmd.addr[LA_W-1:0]] <= cmd.data;
        if (issue && cur_reg.loadable)
            loadable_rd_reg <= loadable_mem[addr_reg[LA_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_reg         <= '0;
            addr_reg        <= '0;
            row_reg         <= '0;
            y_reg           <= '0;
            s1_valid_reg    <= 1'b0;
            s1_loadable_reg <= 1'b0;
            s1_reg          <= '0;
            span_valid_reg  <= 1'b0;
            span_reg        <= '0;
            mask_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_pop && cmd.is_draw)
                    begin
                        cur_reg   <= cmd;
                        addr_reg  <= cmd.addr;
                        y_reg     <= cmd.y;
                        row_reg   <= '0;
                        state_reg <= ST_DRAW;
                    end
                end
                ST_DRAW:
                begin
                    if (issue)
                    begin
                        addr_reg <= addr_next;
                        y_reg    <= y_next;
                        row_reg  <= row_reg + 1'b1;
                        if (is_last)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // Read stage: hold while the output word waits
            if (issue)
            begin
                s1_valid_reg    <= 1'b1;
                s1_loadable_reg <= cur_reg.loadable;
                s1_reg          <= row_attr;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                span_valid_reg <= 1'b1;
                span_reg       <= s1_reg;
                mask_reg       <= s1_loadable_reg ? loadable_rd_reg : fixed_rd_reg;
            end
            else if (!span_stall)
            begin
                span_valid_reg <= 1'b0;
            end
        end
    end

    assign span_valid  = span_valid_reg;
    assign span_x      = span_reg.x;
    assign span_y      = span_reg.y;
    assign set_mask    = mask_reg;
    assign double_size = span_reg.dbl;
    assign paint_unset = span_reg.paint;
    assign main_color  = span_reg.main_color;
    assign alt_color   = span_reg.alt_color;
    assign last_row    = span_reg.last;

endmodule

`default_nettype wire
